/* src/fqd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fqd_pkg;

    // Default sizing of the queue.
    localparam int unsigned DEF_DEPTH = 16;
    localparam int unsigned DEF_WIDTH = 32;

    // Operation codes carried in the input transaction.
    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_DEL = 2'd2;

    // Status codes carried in the output transaction.
    localparam logic [1:0] STS_OK        = 2'd0;
    localparam logic [1:0] STS_EMPTY     = 2'd1;
    localparam logic [1:0] STS_FULL      = 2'd2;
    localparam logic [1:0] STS_NOT_FOUND = 2'd3;

    // Input transaction.
    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] item_value;
    } t_in_item;

    // Output transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] item_out;
        logic        queue_empty;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEQ,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/fifo_queue_with_delete_by_value_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake                Payload
// input     in         i_in_valid / o_in_stall  i_in_data  (fqd_pkg::t_in_item)
// output    out        o_out_valid / i_out_stall o_out_data (fqd_pkg::t_out_item)
//
// Enqueue, dequeue of an empty queue and the unused opcode finish in the accept cycle.
// A dequeue makes one memory read, then the result is staged. A delete walks the single
// read port of the entry memory once, compacting the tail behind the match as it goes.
// Reset clears the head, the count and all valid flags; memory contents are not cleared.
// The input stalls while an operation is in progress or the output register is stalled.

module fifo_queue_with_delete_by_value_unit #(
    parameter int unsigned DEPTH = fqd_pkg::DEF_DEPTH,
    parameter int unsigned WIDTH = fqd_pkg::DEF_WIDTH
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire fqd_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output fqd_pkg::t_out_item       o_out_data
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    // Circular address of a queue position relative to the head.
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(off);
        if (sum >= (CW+1)'(DEPTH)) begin
            sum = sum - (CW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    fqd_pkg::t_state    r_state, n_state;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [CW-1:0]      r_pos, n_pos;
    logic               r_rvalid, n_rvalid;
    logic               r_found, n_found;
    logic [AW-1:0]      r_raddr, n_raddr;
    logic [AW-1:0]      r_last_addr, n_last_addr;
    logic [WIDTH-1:0]   r_word, n_word;
    fqd_pkg::t_out_item r_res, n_res;
    logic               r_out_valid, n_out_valid;
    fqd_pkg::t_out_item r_out, n_out;

    logic               out_free;
    logic               in_acc;
    logic               out_load;
    fqd_pkg::t_out_item out_data;
    logic [CW-1:0]      fin_cnt;

    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [WIDTH-1:0]   wr_data;
    logic               rd_en;
    logic [AW-1:0]      rd_addr;
    logic [WIDTH-1:0]   rd_data;

    fqd_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Handshake qualifiers.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == fqd_pkg::ST_IDLE) && out_free);
    assign in_acc     = i_in_valid && !o_in_stall;

    // Sequencer: next state, memory accesses and result staging.
    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_pos       = r_pos;
        n_rvalid    = r_rvalid;
        n_found     = r_found;
        n_raddr     = r_raddr;
        n_last_addr = r_last_addr;
        n_word      = r_word;
        n_res       = r_res;
        out_load    = 1'b0;
        out_data    = r_res;
        fin_cnt     = r_cnt;
        wr_en       = 1'b0;
        wr_addr     = wrap_add(r_head, r_cnt);
        wr_data     = WIDTH'(i_in_data.item_value);
        rd_en       = 1'b0;
        rd_addr     = r_head;

        unique case (r_state)
            fqd_pkg::ST_IDLE: begin
                if (in_acc) begin
                    unique case (i_in_data.opcode)
                        fqd_pkg::OP_ENQ: begin
                            out_load = 1'b1;
                            if (r_cnt == CW'(DEPTH)) begin
                                out_data = '{fqd_pkg::STS_FULL, 32'd0, 1'b0};
                            end else begin
                                wr_en    = 1'b1;
                                n_cnt    = r_cnt + 1'b1;
                                out_data = '{fqd_pkg::STS_OK, 32'd0, 1'b0};
                            end
                        end
                        fqd_pkg::OP_DEQ: begin
                            if (r_cnt == '0) begin
                                out_load = 1'b1;
                                out_data = '{fqd_pkg::STS_EMPTY, 32'd0, 1'b1};
                            end else begin
                                rd_en   = 1'b1;
                                n_state = fqd_pkg::ST_DEQ;
                            end
                        end
                        fqd_pkg::OP_DEL: begin
                            n_word   = WIDTH'(i_in_data.item_value);
                            n_pos    = '0;
                            n_found  = 1'b0;
                            n_rvalid = 1'b0;
                            n_state  = fqd_pkg::ST_SCAN;
                        end
                        default: begin
                            out_load = 1'b1;
                            out_data = '{fqd_pkg::STS_OK, 32'd0, (r_cnt == '0)};
                        end
                    endcase
                end
            end
            fqd_pkg::ST_DEQ: begin
                // Head word has arrived from the memory.
                n_res   = '{fqd_pkg::STS_OK, 32'(rd_data), (r_cnt == CW'(1))};
                n_head  = wrap_add(r_head, CW'(1));
                n_cnt   = r_cnt - 1'b1;
                n_state = fqd_pkg::ST_DONE;
            end
            fqd_pkg::ST_SCAN: begin
                // Issue the next read while positions remain.
                rd_addr = wrap_add(r_head, r_pos);
                if (r_pos < r_cnt) begin
                    rd_en    = 1'b1;
                    n_pos    = r_pos + 1'b1;
                    n_raddr  = rd_addr;
                    n_rvalid = 1'b1;
                end else begin
                    n_rvalid = 1'b0;
                end
                // Check returned data; after a match, move each word down one place.
                if (r_rvalid) begin
                    if (r_found) begin
                        wr_en   = 1'b1;
                        wr_addr = r_last_addr;
                        wr_data = rd_data;
                    end else if (rd_data == r_word) begin
                        n_found = 1'b1;
                    end
                    n_last_addr = r_raddr;
                end
                // The walk ends once every position is read and checked.
                if ((r_pos == r_cnt) && !r_rvalid) begin
                    fin_cnt = r_found ? (r_cnt - 1'b1) : r_cnt;
                    n_cnt   = fin_cnt;
                    n_res   = '{(r_found ? fqd_pkg::STS_OK : fqd_pkg::STS_NOT_FOUND),
                                32'd0, (fin_cnt == '0)};
                    n_state = fqd_pkg::ST_DONE;
                end
            end
            fqd_pkg::ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_data = r_res;
                    n_state  = fqd_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fqd_pkg::ST_IDLE;
            end
        endcase

        // Output register: a transaction leaves when it is not stalled.
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out       = out_data;
        end else begin
            n_out_valid = r_out_valid && i_out_stall;
            n_out       = r_out;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fqd_pkg::ST_IDLE;
            r_head      <= '0;
            r_cnt       <= '0;
            r_pos       <= '0;
            r_rvalid    <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_cnt       <= n_cnt;
            r_pos       <= n_pos;
            r_rvalid    <= n_rvalid;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_raddr     <= n_raddr;
        r_last_addr <= n_last_addr;
        r_word      <= n_word;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // The stored count never exceeds the capacity.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(DEPTH))
        else $error("entry count above capacity");

    // An accepted enqueue with room grows the queue by one.
    a_enq_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.opcode == fqd_pkg::OP_ENQ) && (r_cnt < CW'(DEPTH)))
        |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("enqueue did not grow the queue");

    // During a walk the read position never passes the count.
    a_scan_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == fqd_pkg::ST_SCAN) |-> (r_pos <= r_cnt))
        else $error("delete walk ran past the tail");

    // The reported empty flag agrees with the count once the result is staged.
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_state == fqd_pkg::ST_DONE))
        |-> (out_data.queue_empty == (r_cnt == '0)))
        else $error("empty flag disagrees with count");
`endif

endmodule

`default_nettype wire

/* src/fqd_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fqd_ram #(
    parameter int unsigned WIDTH = fqd_pkg::DEF_WIDTH,
    parameter int unsigned DEPTH = fqd_pkg::DEF_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Scoreboard: tracks the stored words, predicts the outcome of each accepted
// request and compares the block's responses against those predictions in order.
class fqd_scoreboard;
    logic [31:0]          stored_words[$];
    fqd_pkg::t_out_item   awaited_outcomes[$];
    int                   mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    // Apply one accepted request to the shadow queue and queue up its outcome.
    function void predict_outcome(fqd_pkg::t_in_item req);
        fqd_pkg::t_out_item outcome;
        int                 hit_idx;
        outcome = '0;
        outcome.status = fqd_pkg::STS_OK;
        case (req.opcode)
            fqd_pkg::OP_ENQ: begin
                if (stored_words.size() >= fqd_pkg::DEF_DEPTH) begin
                    outcome.status = fqd_pkg::STS_FULL;
                end else begin
                    stored_words.push_back(req.item_value);
                end
            end
            fqd_pkg::OP_DEQ: begin
                if (stored_words.size() == 0) begin
                    outcome.status = fqd_pkg::STS_EMPTY;
                end else begin
                    outcome.item_out = stored_words.pop_front();
                end
            end
            fqd_pkg::OP_DEL: begin
                // Only the first match from the head is removed.
                hit_idx = -1;
                for (int k = 0; k < stored_words.size(); k++) begin
                    if (hit_idx < 0 && stored_words[k] === req.item_value) begin
                        hit_idx = k;
                    end
                end
                if (hit_idx < 0) begin
                    outcome.status = fqd_pkg::STS_NOT_FOUND;
                end else begin
                    stored_words.delete(hit_idx);
                end
            end
            default: begin
                // The unused opcode leaves the queue alone.
            end
        endcase
        outcome.queue_empty = (stored_words.size() == 0);
        awaited_outcomes.push_back(outcome);
    endfunction

    // Compare one accepted response with the oldest prediction.
    function void check_outcome(fqd_pkg::t_out_item got);
        fqd_pkg::t_out_item want;
        if (awaited_outcomes.size() == 0) begin
            if (mismatch_count < 10) begin
                $display("[%0t] unexpected response: status=%0d item_out=%h empty=%0b",
                         $time, got.status, got.item_out, got.queue_empty);
            end
            mismatch_count++;
        end else begin
            want = awaited_outcomes.pop_front();
            if (got.status !== want.status || got.item_out !== want.item_out ||
                got.queue_empty !== want.queue_empty) begin
                if (mismatch_count < 10) begin
                    $display("[%0t] response mismatch: expected status=%0d item_out=%h empty=%0b",
                             $time, want.status, want.item_out, want.queue_empty);
                    $display("[%0t]                    actual   status=%0d item_out=%h empty=%0b",
                             $time, got.status, got.item_out, got.queue_empty);
                end
                mismatch_count++;
            end
        end
    endfunction
endclass

module tb_top;
    localparam int RAND_ITEMS     = 1325;
    localparam int CALM_ITEMS     = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 40;

    // The opcode that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    fqd_pkg::t_in_item  i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    fqd_pkg::t_out_item o_out_data;

    fqd_scoreboard board;
    logic [31:0]   value_pool[8];
    bit            calm_tail;
    bit            rx_quiet;
    int            stall_left;
    int            rx_cycles;

    fifo_queue_with_delete_by_value_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor both channels at the rising edge; responses are checked first.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                board.check_outcome(o_out_data);
            end
            if (i_in_valid && !o_in_stall) begin
                board.predict_outcome(i_in_data);
            end
        end
    end

    // Output back-pressure in random bursts, with quiet stretches and none at the end.
    always @(negedge i_clk) begin
        rx_cycles++;
        if (rx_cycles % 200 == 0) begin
            rx_quiet = ($urandom_range(0, 3) == 0);
        end
        if (stall_left > 0) begin
            stall_left--;
        end else if (i_rst_n && !calm_tail && !rx_quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 7);
        end
        if (calm_tail) begin
            stall_left = 0;
        end
        i_out_stall <= (stall_left > 0);
    end

    // Watchdog: give up when no transaction moves on either channel for too long.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        do begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end while (quiet_cycles < WATCHDOG_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // Present one request at a falling edge and hold it until it is accepted.
    task automatic send_request(input logic [1:0] opcode, input logic [31:0] value);
        i_in_valid           <= 1'b1;
        i_in_data.opcode     <= opcode;
        i_in_data.item_value <= value;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Drop valid for a number of cycles.
    task automatic hold_off(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // Stop sending until every predicted response has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        while (board.awaited_outcomes.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Pick a word to enqueue: often from a small pool so duplicates occur.
    function automatic logic [31:0] pick_word();
        if ($urandom_range(0, 1) == 0) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom;
    endfunction

    // Pick a delete target: mostly a word that is currently stored.
    function automatic logic [31:0] pick_target();
        int depth_now;
        depth_now = board.stored_words.size();
        if (depth_now > 0 && $urandom_range(0, 3) != 0) begin
            return board.stored_words[$urandom_range(0, depth_now - 1)];
        end
        return pick_word();
    endfunction

    // Choose an opcode; the mode leans the mix toward filling, draining or neither.
    function automatic logic [1:0] pick_opcode(input int mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            return OP_UNUSED;
        end
        case (mode)
            0:       return (roll < 58) ? fqd_pkg::OP_ENQ :
                            (roll < 78) ? fqd_pkg::OP_DEQ : fqd_pkg::OP_DEL;
            1:       return (roll < 28) ? fqd_pkg::OP_ENQ :
                            (roll < 62) ? fqd_pkg::OP_DEQ : fqd_pkg::OP_DEL;
            default: return (roll < 43) ? fqd_pkg::OP_ENQ :
                            (roll < 71) ? fqd_pkg::OP_DEQ : fqd_pkg::OP_DEL;
        endcase
    endfunction

    // Main sequence.
    initial begin
        int          sent;
        int          mode;
        bit          tx_quiet;
        logic [1:0]  opcode;
        logic [31:0] value;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;
        i_out_stall = 1'b0;
        calm_tail  = 1'b0;
        rx_quiet   = 1'b0;
        stall_left = 0;
        rx_cycles  = 0;
        board      = new();

        value_pool[0] = 32'h0000_0000;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int k = 2; k < 8; k++) begin
            value_pool[k] = $urandom;
        end

        // Hold the synchronous reset, then release it.
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-queue corner cases and the unused opcode.
        send_request(fqd_pkg::OP_DEQ, 32'h1234_5678);
        send_request(fqd_pkg::OP_DEL, 32'h0000_0000);
        send_request(OP_UNUSED, 32'hFFFF_FFFF);
        // Deleting the only entry empties the queue.
        send_request(fqd_pkg::OP_ENQ, 32'hFFFF_FFFF);
        send_request(fqd_pkg::OP_DEL, 32'hFFFF_FFFF);
        // Fill to capacity with extremes and duplicates, then overflow.
        for (int k = 0; k < fqd_pkg::DEF_DEPTH; k++) begin
            case (k % 4)
                0:       value = 32'h0000_0000;
                1:       value = 32'hFFFF_FFFF;
                2:       value = 32'hA5A5_0000 | k;
                default: value = $urandom;
            endcase
            send_request(fqd_pkg::OP_ENQ, value);
        end
        send_request(fqd_pkg::OP_ENQ, 32'h5A5A_5A5A);
        // Delete a middle duplicate, miss on a delete, then dequeue the head.
        send_request(fqd_pkg::OP_DEL, 32'hFFFF_FFFF);
        send_request(fqd_pkg::OP_DEL, 32'hDEAD_BEEF);
        send_request(fqd_pkg::OP_DEQ, 32'h0000_0000);

        // Random part.
        sent     = 0;
        mode     = 2;
        tx_quiet = 1'b0;
        while (sent < RAND_ITEMS) begin
            if (sent % 60 == 0) begin
                mode     = $urandom_range(0, 2);
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (sent == RAND_ITEMS / 2) begin
                wait_for_drain();
            end
            if (sent >= RAND_ITEMS - CALM_ITEMS) begin
                calm_tail = 1'b1;
            end
            if (!calm_tail && !tx_quiet && $urandom_range(0, 3) == 0) begin
                hold_off($urandom_range(1, 7));
            end
            opcode = pick_opcode(mode);
            case (opcode)
                fqd_pkg::OP_ENQ: value = pick_word();
                fqd_pkg::OP_DEL: value = pick_target();
                default:         value = $urandom;
            endcase
            send_request(opcode, value);
            if (opcode != OP_UNUSED) begin
                sent++;
            end
        end

        // Let everything come back, then keep watching for stray output.
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (board.mismatch_count == 0 && board.awaited_outcomes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
